// ----- hdl/fdep_pkg.sv -----
// Shared types, constants and helpers for the FAT directory entry parser.
`default_nettype none

package fdep_pkg;

  // Sizes and defaults
  localparam int DEF_MAX_CLUSTER_BYTES = 4096;
  localparam int ENTRY_BYTES           = 32;
  localparam int NAME_BYTES            = 11;
  localparam int EVQ_DEPTH             = 4;

  localparam logic [12:0] RST_CLUSTER_BYTES = 13'd4096;
  localparam logic [7:0]  RST_MAX_ENTRIES   = 8'd16;

  // Marker bytes inside an entry
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] END_MARK     = 8'h00;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [3:0] LFN_ATTR     = 4'hF;
  localparam int         DIR_ATTR_BIT = 4;

  // Byte offsets inside a 32-byte entry
  localparam logic [4:0] POS_FIRST   = 5'd0;
  localparam logic [4:0] POS_ATTR    = 5'd11;
  localparam logic [4:0] POS_CLHI_LO = 5'd20;
  localparam logic [4:0] POS_CLHI_HI = 5'd21;
  localparam logic [4:0] POS_CLLO_LO = 5'd26;
  localparam logic [4:0] POS_CLLO_HI = 5'd27;
  localparam logic [2:0] POS_SIZE_HI = 3'b111;  // offsets 28 to 31
  localparam logic [4:0] POS_LAST    = 5'd31;

  typedef enum logic {
    REG_CLUSTER_BYTES = 1'b0,
    REG_MAX_ENTRIES   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_FILE = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0]  max_entries;
    logic [12:0] cluster_bytes;
  } cfg_t;

  // One classified entry event: a record, a done mark, or both
  typedef struct packed {
    logic        has_rec;
    logic        has_done;
    logic [87:0] name;
    logic [31:0] start_cluster;
    logic [31:0] file_size;
    logic        is_dir;
    logic [7:0]  count;
  } event_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] name_head;
    logic [23:0] name_tail;
    logic [31:0] start_cluster;
    logic [31:0] file_size;
    logic        is_directory;
    logic [7:0]  entry_count;
    logic        last;
  } result_t;

  // Replace a padding space by zero
  function automatic logic [7:0] blank_space(input logic [7:0] b);
    return (b == SPACE_CHAR) ? 8'h00 : b;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/fdep_front.sv -----
// Front end: tracks entry offsets, captures entry fields and classifies each entry.
`default_nettype none

module fdep_front #(
  parameter int MAX_CLUSTER_BYTES = fdep_pkg::DEF_MAX_CLUSTER_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  fdep_pkg::cfg_t   cfg,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             first,
  output logic             ev_push,
  output fdep_pkg::event_t ev
);
  import fdep_pkg::*;

  localparam int OW = $clog2(MAX_CLUSTER_BYTES);
  localparam int LW = OW + 1;
  localparam int CW = (LW > 13) ? LW : 13;

  logic [OW-1:0] offset;
  logic [7:0]    name_store [NAME_BYTES];
  logic [7:0]    attr;
  logic [15:0]   cl_hi;
  logic [15:0]   cl_lo;
  logic [31:0]   size_word;
  logic [7:0]    count;
  logic          fin;

  logic [CW-1:0] cb_ext;
  logic [CW-1:0] cb_clamp;
  logic [LW-1:0] limit;

  logic [OW-1:0] off_eff;
  logic [7:0]    cnt_eff;
  logic          fin_eff;
  logic [OW-1:0] off0;
  logic [LW-1:0] off1;
  logic [4:0]    pos;
  logic          wrap;
  logic          end_mark;
  logic          at_last;
  logic          rec_ok;
  logic [7:0]    cnt_new;
  logic          done31;
  logic          act;

  // Clamp the cluster size and round it down to whole entries
  always_comb begin
    cb_ext = CW'(cfg.cluster_bytes);
    if (cb_ext < CW'(ENTRY_BYTES)) begin
      cb_clamp = CW'(ENTRY_BYTES);
    end else if (cb_ext > CW'(MAX_CLUSTER_BYTES)) begin
      cb_clamp = CW'(MAX_CLUSTER_BYTES);
    end else begin
      cb_clamp = cb_ext;
    end
  end

  assign limit = LW'(cb_clamp & ~CW'(ENTRY_BYTES - 1));

  // Restart on a first byte, then locate the byte inside its entry
  always_comb begin
    off_eff  = first ? '0 : offset;
    cnt_eff  = first ? 8'd0 : count;
    fin_eff  = first ? 1'b0 : fin;
    off0     = ({1'b0, off_eff} >= limit) ? '0 : off_eff;
    off1     = {1'b0, off0} + LW'(1);
    pos      = off0[4:0];
    wrap     = (off1 >= limit);
    end_mark = (pos == POS_FIRST) && (data_byte == END_MARK);
    at_last  = (pos == POS_LAST);
    rec_ok   = (name_store[0] != DELETED_MARK) && (attr[3:0] != LFN_ATTR);
    cnt_new  = cnt_eff + {7'd0, rec_ok};
    done31   = wrap || (rec_ok && (cnt_new >= cfg.max_entries));
    act      = accept && !fin_eff;
  end

  // Build the entry event
  always_comb begin
    ev_push          = act && (end_mark || (at_last && (rec_ok || done31)));
    ev.has_rec       = !end_mark && at_last && rec_ok;
    ev.has_done      = end_mark || (at_last && done31);
    ev.name          = {name_store[0], name_store[1], name_store[2], name_store[3],
                        name_store[4], name_store[5], name_store[6], name_store[7],
                        name_store[8], name_store[9], name_store[10]};
    ev.start_cluster = {cl_hi, cl_lo};
    ev.file_size     = {data_byte, size_word[23:0]};
    ev.is_dir        = attr[DIR_ATTR_BIT];
    ev.count         = end_mark ? cnt_eff : cnt_new;
  end

  // Capture name bytes
  always_ff @(posedge clk) begin
    if (act && (pos < 5'(NAME_BYTES))) begin
      name_store[pos[3:0]] <= data_byte;
    end
  end

  // Advance offset, count and field words
  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      count     <= 8'd0;
      fin       <= 1'b0;
      attr      <= 8'd0;
      cl_hi     <= 16'd0;
      cl_lo     <= 16'd0;
      size_word <= 32'd0;
    end else if (act) begin
      if (pos == POS_ATTR) begin
        attr <= data_byte;
      end
      if (pos == POS_CLHI_LO) begin
        cl_hi[7:0] <= data_byte;
      end
      if (pos == POS_CLHI_HI) begin
        cl_hi[15:8] <= data_byte;
      end
      if (pos == POS_CLLO_LO) begin
        cl_lo[7:0] <= data_byte;
      end
      if (pos == POS_CLLO_HI) begin
        cl_lo[15:8] <= data_byte;
      end
      if (pos[4:2] == POS_SIZE_HI) begin
        size_word[{pos[1:0], 3'b000} +: 8] <= data_byte;
      end
      count <= at_last ? cnt_new : cnt_eff;
      if (end_mark) begin
        offset <= off0;
        fin    <= 1'b1;
      end else if (wrap) begin
        offset <= '0;
        fin    <= 1'b1;
      end else begin
        offset <= off1[OW-1:0];
        fin    <= at_last && done31;
      end
    end
  end

  // Ignored bytes leave the listing untouched
  a_fin_no_event: assert property (@(posedge clk) disable iff (rst)
    accept && !first && fin |-> !ev_push)
    else $error("event pushed after listing finished");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !first && fin |=> $stable(offset) && $stable(count))
    else $error("state changed on an ignored byte");

  a_ev_nonempty: assert property (@(posedge clk) disable iff (rst)
    ev_push |-> ev.has_rec || ev.has_done)
    else $error("event pushed with nothing to report");

endmodule

`default_nettype wire

// ----- hdl/fdep_evq.sv -----
// Short event queue between the entry classifier and the result formatter.
`default_nettype none

module fdep_evq #(
  parameter int DEPTH = fdep_pkg::EVQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  fdep_pkg::event_t wr_data,
  output logic             full,
  input  logic             rd,
  output logic             valid,
  output fdep_pkg::event_t rd_data
);
  import fdep_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  event_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign full    = (fill == NW'(DEPTH));
  assign valid   = (fill != '0);
  assign rd_data = slots[rd_ptr];

  // Store incoming events
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd && valid) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if ((wr && !full) && !(rd && valid)) begin
        fill <= fill + NW'(1);
      end else if (!(wr && !full) && (rd && valid)) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fdep_back.sv -----
// Back end: expands entry events into result words and holds the output register.
`default_nettype none

module fdep_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              ev_valid,
  input  fdep_pkg::event_t  ev,
  output logic              ev_pop,
  input  logic              pop,
  output logic              res_valid,
  output fdep_pkg::result_t res
);
  import fdep_pkg::*;

  logic       phase;     // record already sent, done word still owed
  logic       load;
  logic       take;
  logic       send_rec;
  logic [7:0] nbytes [NAME_BYTES];
  result_t    res_next;

  // Blank padding spaces in the name
  always_comb begin
    for (int j = 0; j < NAME_BYTES; j++) begin
      nbytes[j] = blank_space(ev.name[8*(NAME_BYTES-1-j) +: 8]);
    end
  end

  // Select the next result word
  always_comb begin
    load     = !res_valid || pop;
    take     = load && ev_valid;
    send_rec = ev.has_rec && !phase;
    ev_pop   = take && (!send_rec || !ev.has_done);
    if (send_rec) begin
      res_next.kind          = KIND_FILE;
      res_next.name_head     = {nbytes[0], nbytes[1], nbytes[2], nbytes[3],
                                nbytes[4], nbytes[5], nbytes[6], nbytes[7]};
      res_next.name_tail     = {nbytes[8], nbytes[9], nbytes[10]};
      res_next.start_cluster = ev.start_cluster;
      res_next.file_size     = ev.file_size;
      res_next.is_directory  = ev.is_dir;
      res_next.entry_count   = 8'd0;
      res_next.last          = !ev.has_done;
    end else begin
      res_next.kind          = KIND_DONE;
      res_next.name_head     = 64'd0;
      res_next.name_tail     = 24'd0;
      res_next.start_cluster = 32'd0;
      res_next.file_size     = 32'd0;
      res_next.is_directory  = 1'b0;
      res_next.entry_count   = ev.count;
      res_next.last          = 1'b1;
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  // Track output valid and the pending done word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
      phase     <= send_rec && ev.has_done;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  a_phase_has_event: assert property (@(posedge clk) disable iff (rst)
    phase |-> ev_valid && ev.has_done)
    else $error("pending done word without its event");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_DONE |-> res.last)
    else $error("done word not marked last");

  a_phase_follows_rec: assert property (@(posedge clk) disable iff (rst)
    $rose(phase) |-> res_valid && res.kind == KIND_FILE && !res.last)
    else $error("done word owed without a preceding record");

endmodule

`default_nettype wire

// ----- hdl/fat_directory_entry_parser_core.sv -----
// Top level of the FAT directory entry parser: config registers and channel wiring.
//
// Input queue: drive data_byte and first with push; a byte is taken at an edge with
// push high and full low. first restarts the listing at offset zero. One byte per
// cycle is sustained; full rises only when the four-deep event queue is full,
// which needs the result side to stall for several entries.
// Result queue: while empty is low the oldest word sits on kind..last; pop takes it.
// A word is shown once the event of its byte (the last byte of an entry, or a zero
// first byte) has passed the event queue and the output register. A record
// followed by its done word leaves on two consecutive pops; at most two words come
// from one byte; the formatter sends one word per cycle while pop is high.
// When pop stays low the output register holds its word and events wait in the
// queue; byte intake continues until that queue fills.
// Configuration: cfg_index selects cluster_bytes (0) or max_entries (1), cfg_data
// carries the value; cfg_ready is always high. Write only while the block is idle.
// Reset clears offsets, counts and queues and loads cluster_bytes 4096 and
// max_entries 16; bytes after reset parse as if a cluster had just started.
`default_nettype none

module fat_directory_entry_parser_core #(
  parameter int MAX_CLUSTER_BYTES = fdep_pkg::DEF_MAX_CLUSTER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        first,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [63:0] name_head,
  output logic [23:0] name_tail,
  output logic [31:0] start_cluster,
  output logic [31:0] file_size,
  output logic        is_directory,
  output logic [7:0]  entry_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import fdep_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    ev_push;
  event_t  ev_in;
  logic    ev_valid;
  logic    ev_pop;
  event_t  ev_head;
  logic    res_valid;
  result_t res;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cluster_bytes <= RST_CLUSTER_BYTES;
      cfg.max_entries   <= RST_MAX_ENTRIES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLUSTER_BYTES: cfg.cluster_bytes <= cfg_data;
        REG_MAX_ENTRIES:   cfg.max_entries   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fdep_front #(
    .MAX_CLUSTER_BYTES(MAX_CLUSTER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .data_byte(data_byte),
    .first    (first),
    .ev_push  (ev_push),
    .ev       (ev_in)
  );

  fdep_evq #(
    .DEPTH(EVQ_DEPTH)
  ) u_evq (
    .clk    (clk),
    .rst    (rst),
    .wr     (ev_push),
    .wr_data(ev_in),
    .full   (full),
    .rd     (ev_pop),
    .valid  (ev_valid),
    .rd_data(ev_head)
  );

  fdep_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev_valid),
    .ev       (ev_head),
    .ev_pop   (ev_pop),
    .pop      (pop),
    .res_valid(res_valid),
    .res      (res)
  );

  // Drive result ports
  assign empty         = !res_valid;
  assign kind          = res.kind;
  assign name_head     = res.name_head;
  assign name_tail     = res.name_tail;
  assign start_cluster = res.start_cluster;
  assign file_size     = res.file_size;
  assign is_directory  = res.is_directory;
  assign entry_count   = res.entry_count;
  assign last          = res.last;

endmodule

`default_nettype wire
